### src/kms_pkg.sv
// kms_pkg: sizes, codes and shared types of the keyed matrix variable store.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package kms_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int ROWS        = 4;
  localparam int COLS        = 4;
  localparam int NAME_CHARS  = 8;

  localparam int KEY_W   = 64;
  localparam int VAL_W   = 64;
  localparam int IDX_IN_W = 4;
  localparam int WORDS   = MAX_ENTRIES * ROWS * COLS;

  localparam int ENT_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  localparam logic [KEY_W-1:0] KEY_MASK =
    (NAME_CHARS >= 8) ? {KEY_W{1'b1}} : ((KEY_W'(1) << (8 * NAME_CHARS)) - KEY_W'(1));

  localparam logic [VAL_W-1:0] MINUS_ONE_BITS = 64'hBFF0_0000_0000_0000;

  localparam logic [IDX_IN_W:0] ROW_LIMIT = (IDX_IN_W + 1)'(ROWS);
  localparam logic [IDX_IN_W:0] COL_LIMIT = (IDX_IN_W + 1)'(COLS);

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] MODE_MATRIX = 2'd0;
  localparam logic [1:0] MODE_ROW    = 2'd1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [ENT_W-1:0] idx;
  } lookup_t;

endpackage

`default_nettype wire

### src/keyed_matrix_variable_store.sv
// keyed_matrix_variable_store: top level, item control and the matrix word memory.
// Depends on kms_pkg and kms_key_table.
//
//   channel | direction | fields                                          | handshake
//   in      | input     | operation name_key index_mode row/col write_val | in_valid_i / in_stall_o
//   out     | output    | read_value status                               | out_valid_o / out_stall_i
//
// One item at a time. Lookup checks stored entries in order until a match or past the last.
// Read: lookup, then a word read through the registered matrix memory read port.
// Write: lookup, then one memory write per word: ROWS*COLS for a whole matrix or a
// new entry (its clear and fill share one sweep), COLS for a row, one for an element.
// The result waits in an output register; no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module keyed_matrix_variable_store (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic                             operation_i,
  input  wire logic [kms_pkg::KEY_W-1:0]        name_key_i,
  input  wire logic [1:0]                       index_mode_i,
  input  wire logic [kms_pkg::IDX_IN_W-1:0]     row_index_i,
  input  wire logic [kms_pkg::IDX_IN_W-1:0]     col_index_i,
  input  wire logic [kms_pkg::VAL_W-1:0]        write_value_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic [kms_pkg::VAL_W-1:0]        read_value_o,
  output      logic [1:0]                       status_o
);
  import kms_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_MREAD = 6'b000100,
    S_MDATA = 6'b001000,
    S_FILL  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // latched item
  logic                op_q;
  logic [KEY_W-1:0]    key_q;
  logic [1:0]          mode_q;
  logic [IDX_IN_W-1:0] row_q, col_q;
  logic [VAL_W-1:0]    val_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [ENT_W-1:0] entry_q, entry_d;
  logic [ROW_W-1:0] r_q, r_d;
  logic [COL_W-1:0] c_q, c_d;
  logic             all_q, all_d, rowsw_q, rowsw_d;
  logic [VAL_W-1:0] res_val_q, res_val_d;
  status_e          res_st_q, res_st_d;
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] out_val_q;
  status_e          out_st_q;
  logic             out_load;

  logic             accept, range_bad, in_elem, q_elem, full;
  logic             key_wr, mat_we, sel, fill_last;
  logic [VAL_W-1:0] mat_wdata, mat_rd_q;
  logic [WORD_W-1:0] mat_addr;
  lookup_t          lookup;

  logic [VAL_W-1:0] mat_mem [WORDS];

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_elem   = (index_mode_i != MODE_MATRIX) && (index_mode_i != MODE_ROW);
  assign range_bad = ((index_mode_i != MODE_MATRIX) && ({1'b0, row_index_i} >= ROW_LIMIT)) ||
                     (in_elem && ({1'b0, col_index_i} >= COL_LIMIT));
  assign q_elem    = (mode_q != MODE_MATRIX) && (mode_q != MODE_ROW);
  assign full      = (count_q == CNT_W'(MAX_ENTRIES));

  kms_key_table u_keys (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept && !range_bad),
    .key_i    (key_q),
    .count_i  (count_q),
    .wr_en_i  (key_wr),
    .wr_idx_i (count_q[ENT_W-1:0]),
    .wr_key_i (key_q),
    .lookup_o (lookup)
  );

  assign key_wr = (state_q == S_SCAN) && lookup.done && !lookup.hit &&
                  (op_q == OP_WRITE) && !full;

  assign mat_addr = WORD_W'((WORD_W'(entry_q) * WORD_W'(ROWS) + WORD_W'(r_q)) * WORD_W'(COLS)
                            + WORD_W'(c_q));

  assign sel = (mode_q == MODE_MATRIX) ||
               ((mode_q == MODE_ROW) && (r_q == ROW_W'(row_q))) ||
               (q_elem && (r_q == ROW_W'(row_q)) && (c_q == COL_W'(col_q)));
  assign mat_wdata = sel ? val_q : '0;
  assign mat_we    = (state_q == S_FILL);
  assign fill_last = all_q   ? ((r_q == ROW_W'(ROWS - 1)) && (c_q == COL_W'(COLS - 1))) :
                     rowsw_q ? (c_q == COL_W'(COLS - 1)) : 1'b1;

  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem[mat_addr] <= mat_wdata;
    end
    mat_rd_q <= mat_mem[mat_addr];
  end

  assign out_load = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    entry_d     = entry_q;
    r_d         = r_q;
    c_d         = c_q;
    all_d       = all_q;
    rowsw_d     = rowsw_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (range_bad) begin
            res_val_d = '0;
            res_st_d  = ST_RANGE;
            state_d   = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (lookup.done) begin
          res_val_d = '0;
          res_st_d  = ST_OK;
          if (op_q == OP_READ) begin
            if (lookup.hit) begin
              entry_d = lookup.idx;
              r_d     = (mode_q != MODE_MATRIX) ? ROW_W'(row_q) : '0;
              c_d     = q_elem ? COL_W'(col_q) : '0;
              state_d = S_MREAD;
            end else begin
              res_val_d = MINUS_ONE_BITS;
              res_st_d  = ST_MISS;
              state_d   = S_RESP;
            end
          end else if (!lookup.hit && full) begin
            res_st_d = ST_FULL;
            state_d  = S_RESP;
          end else begin
            entry_d = lookup.hit ? lookup.idx : count_q[ENT_W-1:0];
            if (!lookup.hit) begin
              count_d = count_q + CNT_W'(1);
            end
            all_d   = !lookup.hit || (mode_q == MODE_MATRIX);
            rowsw_d = lookup.hit && (mode_q == MODE_ROW);
            r_d     = (!lookup.hit || (mode_q == MODE_MATRIX)) ? '0 : ROW_W'(row_q);
            c_d     = (!lookup.hit || !q_elem) ? '0 : COL_W'(col_q);
            state_d = S_FILL;
          end
        end
      end
      S_MREAD: begin
        state_d = S_MDATA;
      end
      S_MDATA: begin
        res_val_d = mat_rd_q;
        state_d   = S_RESP;
      end
      S_FILL: begin
        if (fill_last) begin
          state_d = S_RESP;
        end else if (c_q == COL_W'(COLS - 1)) begin
          c_d = '0;
          r_d = r_q + ROW_W'(1);
        end else begin
          c_d = c_q + COL_W'(1);
        end
      end
      S_RESP: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      key_q  <= name_key_i & KEY_MASK;
      mode_q <= index_mode_i;
      row_q  <= row_index_i;
      col_q  <= col_index_i;
      val_q  <= write_value_i;
    end
    entry_q   <= entry_d;
    r_q       <= r_d;
    c_q       <= c_d;
    all_q     <= all_d;
    rowsw_q   <= rowsw_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_val_q <= res_val_q;
      out_st_q  <= res_st_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_val_q;
  assign status_o     = out_st_q;

endmodule

`default_nettype wire

### src/kms_key_table.sv
// kms_key_table: name key memory with a sequential lookup, one key per cycle.
// Depends on kms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kms_key_table (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [kms_pkg::KEY_W-1:0]  key_i,
  input  wire logic [kms_pkg::CNT_W-1:0]  count_i,
  input  wire logic                       wr_en_i,
  input  wire logic [kms_pkg::ENT_W-1:0]  wr_idx_i,
  input  wire logic [kms_pkg::KEY_W-1:0]  wr_key_i,
  output kms_pkg::lookup_t                lookup_o
);
  import kms_pkg::*;

  logic [KEY_W-1:0] key_mem [MAX_ENTRIES];
  logic [KEY_W-1:0] rd_key_q;
  logic [ENT_W-1:0] raddr;
  logic [CNT_W-1:0] chk_q, chk_d, chk_next;
  logic             busy_q, busy_d;
  logic             past_end, match;

  assign chk_next = chk_q + CNT_W'(1);
  assign raddr    = start_i ? '0 : chk_next[ENT_W-1:0];
  assign past_end = chk_q >= count_i;
  assign match    = !past_end && (rd_key_q == key_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_idx_i] <= wr_key_i;
    end
    rd_key_q <= key_mem[raddr];
  end

  always_comb begin
    busy_d = busy_q;
    chk_d  = chk_q;
    if (start_i) begin
      busy_d = 1'b1;
      chk_d  = '0;
    end else if (busy_q) begin
      if (past_end || match) begin
        busy_d = 1'b0;
      end else begin
        chk_d = chk_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      chk_q  <= '0;
    end else begin
      busy_q <= busy_d;
      chk_q  <= chk_d;
    end
  end

  assign lookup_o.done = busy_q && (past_end || match);
  assign lookup_o.hit  = match;
  assign lookup_o.idx  = chk_q[ENT_W-1:0];

endmodule

`default_nettype wire

### src/kms_checker.sv
// kms_checker: port-level checks of the keyed matrix variable store, bound to the top.
// Depends on kms_pkg and keyed_matrix_variable_store.
`timescale 1ns / 1ps
`default_nettype none

module kms_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         operation_i,
  input wire logic [kms_pkg::KEY_W-1:0]    name_key_i,
  input wire logic [1:0]                   index_mode_i,
  input wire logic [kms_pkg::IDX_IN_W-1:0] row_index_i,
  input wire logic [kms_pkg::IDX_IN_W-1:0] col_index_i,
  input wire logic [kms_pkg::VAL_W-1:0]    write_value_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [kms_pkg::VAL_W-1:0]    read_value_o,
  input wire logic [1:0]                   status_o
);
  import kms_pkg::*;

  logic unused_in;
  assign unused_in = operation_i ^ (^name_key_i) ^ (^index_mode_i) ^ (^row_index_i) ^
                     (^col_index_i) ^ (^write_value_i);

  // one item in flight: busy in the cycle after a transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(read_value_o) && $stable(status_o)))
    else $error("stalled result changed");

  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_MISS) |-> (read_value_o == MINUS_ONE_BITS))
    else $error("read miss without -1.0 pattern");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL || status_o == ST_RANGE)) |-> (read_value_o == '0))
    else $error("flagged result carries a value");

endmodule

bind keyed_matrix_variable_store kms_checker u_kms_checker (.*);

`default_nettype wire
